/* rtl/ptc_pkg.sv */
// Package for the pressure and temperature compensation block.
// Holds constants, the configuration struct and shared arithmetic helpers.
// No dependencies.
`default_nettype none
package ptc_pkg;

  localparam int unsigned RawW  = 20;
  localparam int unsigned WordW = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DivStages = 32;

  localparam logic [WordW-1:0] PressOffset = 32'd64000;
  localparam logic [WordW-1:0] PressBase   = 32'd1048576;
  localparam logic [WordW-1:0] PressScale  = 32'd3125;
  localparam logic [WordW-1:0] HalfScale   = 32'd32768;
  localparam logic [WordW-1:0] TempRound   = 32'd128;
  localparam logic [WordW-1:0] TempMul     = 32'd5;

  typedef enum logic [2:0] {
    RegT1  = 3'd0,
    RegT2  = 3'd1,
    RegT3  = 3'd2,
    RegP12 = 3'd3,
    RegP34 = 3'd4,
    RegP56 = 3'd5,
    RegP78 = 3'd6,
    RegP9  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [31:0] p12;
    logic [31:0] p34;
    logic [31:0] p56;
    logic [31:0] p78;
    logic [15:0] p9;
  } cfg_t;

  typedef struct packed {
    logic [31:0] temp;
    logic        zero;
    logic        halved;
  } side_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x) >>> n;
    return $unsigned(s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] f;
    f = a * b;
    return f[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/ptc_if.sv */
// Channel interfaces for the compensation block: raw input and result.
// Depends on ptc_pkg.
`default_nettype none
interface ptc_in_if import ptc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_temp;
  logic [RawW-1:0] raw_press;
  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface ptc_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] temp_centideg;
  logic [31:0] press_pascal;
  logic        divisor_zero;
  modport source (output valid, output temp_centideg, output press_pascal,
                  output divisor_zero, input ready);
  modport sink   (input valid, input temp_centideg, input press_pascal,
                  input divisor_zero, output ready);
endinterface
`default_nettype wire

/* rtl/pressure_temperature_compensation.sv */
// Top level of the pressure and temperature compensation block.
// Depends on ptc_pkg, ptc_if, ptc_regs, ptc_front, ptc_div and ptc_back.
//
//   channel | dir | payload
//   in_i    | in  | raw_temp[19:0], raw_press[19:0]
//   out_o   | out | temp_centideg[31:0], press_pascal[31:0], divisor_zero
//   apb     | in  | 8 calibration registers at byte address 4*i
//
// One transfer in per cycle while the output is not stalled. Stages: 10 front, 32 divider
// (one quotient bit each) and 3 back, the last being the output register.
// Reset clears all valid bits and the calibration registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module pressure_temperature_compensation import ptc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ptc_in_if.sink                in_i,
  ptc_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);
  cfg_t        cfg;
  logic        en;
  logic        f_v, d_v;
  logic [31:0] dividend, divisor, quot;
  side_t       f_side, d_side;

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  ptc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  ptc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .raw_temp_i(in_i.raw_temp), .raw_press_i(in_i.raw_press), .cfg_i(cfg),
    .valid_o(f_v), .dividend_o(dividend), .divisor_o(divisor), .side_o(f_side)
  );

  ptc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v), .dividend_i(dividend),
    .divisor_i(divisor), .side_i(f_side),
    .valid_o(d_v), .quot_o(quot), .side_o(d_side)
  );

  ptc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v), .quot_i(quot), .side_i(d_side),
    .cfg_i(cfg), .valid_o(out_o.valid), .temp_o(out_o.temp_centideg),
    .press_o(out_o.press_pascal), .zero_o(out_o.divisor_zero)
  );
endmodule
`default_nettype wire

/* rtl/ptc_regs.sv */
// APB-style calibration register file.
// Depends on ptc_pkg.
`default_nettype none
module ptc_regs import ptc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);
  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        RegT1:  cfg_q.t1  <= pwdata[15:0];
        RegT2:  cfg_q.t2  <= pwdata[15:0];
        RegT3:  cfg_q.t3  <= pwdata[15:0];
        RegP12: cfg_q.p12 <= pwdata;
        RegP34: cfg_q.p34 <= pwdata;
        RegP56: cfg_q.p56 <= pwdata;
        RegP78: cfg_q.p78 <= pwdata;
        RegP9:  cfg_q.p9  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegT1:   prdata = {16'd0, cfg_q.t1};
      RegT2:   prdata = {16'd0, cfg_q.t2};
      RegT3:   prdata = {16'd0, cfg_q.t3};
      RegP12:  prdata = cfg_q.p12;
      RegP34:  prdata = cfg_q.p34;
      RegP56:  prdata = cfg_q.p56;
      RegP78:  prdata = cfg_q.p78;
      RegP9:   prdata = {16'd0, cfg_q.p9};
      default: prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/ptc_front.sv */
// Temperature compensation and pressure divisor/dividend pipeline.
// Ten register stages, at most one multiply deep per stage. Depends on ptc_pkg.
`default_nettype none
module ptc_front import ptc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [RawW-1:0] raw_temp_i,
  input  wire logic [RawW-1:0] raw_press_i,
  input  wire cfg_t            cfg_i,
  output logic                 valid_o,
  output logic [31:0]          dividend_o,
  output logic [31:0]          divisor_o,
  output side_t                side_o
);
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  logic [31:0] rt, rp;
  logic [9:0]  v_q;

  assign t1 = {16'd0, cfg_i.t1};
  assign t2 = sx16(cfg_i.t2);
  assign t3 = sx16(cfg_i.t3);
  assign p1 = {16'd0, cfg_i.p12[15:0]};
  assign p2 = sx16(cfg_i.p12[31:16]);
  assign p3 = sx16(cfg_i.p34[15:0]);
  assign p4 = sx16(cfg_i.p34[31:16]);
  assign p5 = sx16(cfg_i.p56[15:0]);
  assign p6 = sx16(cfg_i.p56[31:16]);
  assign rt = {{(WordW-RawW){1'b0}}, raw_temp_i};
  assign rp = {{(WordW-RawW){1'b0}}, raw_press_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[8:0], valid_i};
    end
  end

  logic [31:0] x1_q, d_q, ap1_q;
  logic [31:0] m1_q, dd_q, ap2_q;
  logic [31:0] a3_q, m2_q, ap3_q;
  logic [31:0] fine_q, ap4_q;
  logic [31:0] tm_q, pa_q, ap5_q;
  logic [31:0] temp6_q, qq_q, pa5_q, pa6_q, ap6_q;
  logic [31:0] temp7_q, b1_q, c1_q, c2_q, pa5b_q, ap7_q;
  logic [31:0] temp8_q, bs_q, av_q, ap8_q;
  logic [31:0] temp9_q, m9_q, pb_q;
  logic [31:0] temp10_q, den_q, pp_q;
  logic [31:0] q6;

  assign q6 = asr(pa_q, 2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= (rt >> 3) - (t1 << 1);
      d_q   <= (rt >> 4) - t1;
      ap1_q <= rp;

      m1_q  <= mul32(x1_q, t2);
      dd_q  <= mul32(d_q, d_q);
      ap2_q <= ap1_q;

      a3_q  <= asr(m1_q, 11);
      m2_q  <= mul32(asr(dd_q, 12), t3);
      ap3_q <= ap2_q;

      fine_q <= a3_q + asr(m2_q, 14);
      ap4_q  <= ap3_q;

      tm_q  <= mul32(fine_q, TempMul) + TempRound;
      pa_q  <= asr(fine_q, 1) - PressOffset;
      ap5_q <= ap4_q;

      temp6_q <= asr(tm_q, 8);
      qq_q    <= mul32(q6, q6);
      pa5_q   <= mul32(pa_q, p5);
      pa6_q   <= pa_q;
      ap6_q   <= ap5_q;

      temp7_q <= temp6_q;
      b1_q    <= mul32(asr(qq_q, 11), p6);
      c1_q    <= mul32(p3, asr(qq_q, 13));
      c2_q    <= mul32(p2, pa6_q);
      pa5b_q  <= pa5_q;
      ap7_q   <= ap6_q;

      temp8_q <= temp7_q;
      bs_q    <= asr(b1_q + (pa5b_q << 1), 2) + (p4 << 16);
      av_q    <= asr(asr(c1_q, 3) + asr(c2_q, 1), 18);
      ap8_q   <= ap7_q;

      temp9_q <= temp8_q;
      m9_q    <= mul32(HalfScale + av_q, p1);
      pb_q    <= (PressBase - ap8_q) - asr(bs_q, 12);

      temp10_q <= temp9_q;
      den_q    <= asr(m9_q, 15);
      pp_q     <= mul32(pb_q, PressScale);
    end
  end

  assign valid_o     = v_q[9];
  assign divisor_o   = den_q;
  assign dividend_o  = pp_q[31] ? pp_q : (pp_q << 1);
  assign side_o.temp   = temp10_q;
  assign side_o.zero   = (den_q == '0);
  assign side_o.halved = pp_q[31];
endmodule
`default_nettype wire

/* rtl/ptc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Carries sideband alongside the quotient. Depends on ptc_pkg.
`default_nettype none
module ptc_div import ptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  input  wire side_t       side_i,
  output logic             valid_o,
  output logic [31:0]      quot_o,
  output side_t            side_o
);
  logic [31:0] rem_q  [1:DivStages];
  logic [31:0] word_q [1:DivStages];
  logic [31:0] den_q  [1:DivStages];
  side_t       side_q [1:DivStages];
  logic        v_q    [1:DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [31:0] rem_in;
    logic [31:0] word_in;
    logic [31:0] den_in;
    side_t       side_in;
    logic        v_in;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign word_in = dividend_i;
      assign den_in  = divisor_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s];
      assign word_in = word_q[s];
      assign den_in  = den_q[s];
      assign side_in = side_q[s];
      assign v_in    = v_q[s];
    end

    assign trial = {rem_in, word_in[31]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? diff[31:0] : trial[31:0];
        word_q[s+1] <= {word_in[30:0], ge};
        den_q[s+1]  <= den_in;
        side_q[s+1] <= side_in;
      end
    end
  end

  assign valid_o = v_q[DivStages];
  assign quot_o  = word_q[DivStages];
  assign side_o  = side_q[DivStages];
endmodule
`default_nettype wire

/* rtl/ptc_back.sv */
// Pressure correction after the division, ending in the output register.
// Three register stages. Depends on ptc_pkg.
`default_nettype none
module ptc_back import ptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] quot_i,
  input  wire side_t       side_i,
  input  wire cfg_t        cfg_i,
  output logic             valid_o,
  output logic [31:0]      temp_o,
  output logic [31:0]      press_o,
  output logic             zero_o
);
  logic [31:0] p7, p8, p9, p;
  logic [1:0]  v_q;
  logic        out_v_q;

  assign p7 = sx16(cfg_i.p78[15:0]);
  assign p8 = sx16(cfg_i.p78[31:16]);
  assign p9 = sx16(cfg_i.p9);
  assign p  = side_i.halved ? (quot_i << 1) : quot_i;

  logic [31:0] pa_q, sq_q, pp8_q;
  side_t       sa_q;
  logic [31:0] pb_q, m9_q, b_q;
  side_t       sb_q;
  logic [31:0] temp_q, press_q;
  logic        zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[0], valid_i};
      out_v_q <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= p;
      sq_q  <= mul32(p >> 3, p >> 3);
      pp8_q <= mul32(p >> 2, p8);
      sa_q  <= side_i;

      pb_q <= pa_q;
      m9_q <= mul32(p9, sq_q >> 13);
      b_q  <= asr(pp8_q, 13);
      sb_q <= sa_q;

      temp_q  <= sb_q.temp;
      zero_q  <= sb_q.zero;
      press_q <= sb_q.zero ? '0 : pb_q + asr(asr(m9_q, 12) + b_q + p7, 4);
    end
  end

  assign valid_o = out_v_q;
  assign temp_o  = temp_q;
  assign press_o = press_q;
  assign zero_o  = zero_q;
endmodule
`default_nettype wire
